>>> hw/rtl/vocg_pkg.sv
// Shared types and constants for the voxel occupancy and cost grid.
// Holds the grid geometry, word structs, opcodes and cost saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package vocg_pkg;

	// Grid geometry.
	localparam int GRID_X     = 64;
	localparam int GRID_Y     = 64;
	localparam int GRID_Z     = 32;
	localparam int COST_BITS  = 16;
	localparam int CELL_COUNT = GRID_X * GRID_Y * GRID_Z;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// Fixed field widths.
	localparam int POS_W     = 24;
	localparam int EXT_W     = 23;
	localparam int INV_W     = 16;
	localparam int CIDX_W    = 8;
	localparam int DIFF_W    = POS_W + 1;
	localparam int FRAC_SH   = 16;
	localparam int PROD_W    = EXT_W + INV_W;
	localparam int CELLV_W   = PROD_W - FRAC_SH;
	localparam int OUTCOST_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam logic [32:0] COST_MAX = (33'd1 << COST_BITS) - 33'd1;
	localparam logic [32:0] OUTCOST_MAX = (33'd1 << OUTCOST_W) - 33'd1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RES  = 3'd6;

	typedef enum logic [1:0] {
		OP_SET_OCC    = 2'd0,
		OP_RAISE_COST = 2'd1,
		OP_READ_POS   = 2'd2,
		OP_READ_CELL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		op_t                      op;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [CIDX_W-1:0]        cell_x;
		logic [CIDX_W-1:0]        cell_y;
		logic [CIDX_W-1:0]        cell_z;
		logic                     occ_value;
		logic [15:0]              cost_value;
	} req_t;

	typedef struct packed {
		logic                 status;
		logic                 occupancy;
		logic [OUTCOST_W-1:0] cost;
	} rsp_t;

	typedef struct packed {
		logic                 occ;
		logic [COST_BITS-1:0] cost;
	} cell_t;

	// Candidate cost clipped to the stored cost width.
	function automatic logic [COST_BITS-1:0] sat_cost_in(input logic [15:0] cand);
		logic [32:0] w;
		w = 33'(cand);
		if (w > COST_MAX) w = COST_MAX;
		return COST_BITS'(w);
	endfunction

	// Stored cost clipped to the 16-bit output field.
	function automatic logic [OUTCOST_W-1:0] sat_cost_out(input logic [COST_BITS-1:0] c);
		logic [32:0] w;
		w = 33'(c);
		if (w > OUTCOST_MAX) w = OUTCOST_MAX;
		return w[OUTCOST_W-1:0];
	endfunction

endpackage

>>> hw/rtl/voxel_occupancy_cost_grid.sv
// Top level of the voxel occupancy and cost grid: request sequencer, cell store.
// Depends on vocg_pkg.
`timescale 1ns / 1ps

// Usage
// - Request channel (in_valid/in_ready/in_word): one word per request, either a
//   Q.8 position (ops set occupancy, raise cost, read by position) or a cell
//   index (read occupancy by cell).
// - Result channel (out_valid/out_ready/out_word): exactly one word per request,
//   in request order. status = 1 flags a position or cell outside the map;
//   such a request never touches the store and returns zero data.
// - Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes,
//   only while no request is in flight.
// Timing
// - A request walks diff, multiply, lookup (memory read) and commit (memory
//   write plus result register); the result is registered at commit, and the
//   next word is taken only after the previous request has returned to idle.
//   One request owns the memory from accept to commit, so no forwarding.
// - If the receiver stalls with a result pending, the next request still runs
//   up to commit and holds there until the result register frees.
// Reset
// - arst_n restores the register defaults, then a clearing pass writes zero to
//   all CELL_COUNT cells (131072 for the 64x64x32 grid), one per cycle.
//   in_ready stays low during the pass; config writes are taken as usual.
module voxel_occupancy_cost_grid (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  vocg_pkg::req_t                       in_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output vocg_pkg::rsp_t                       out_word,
	input  logic                                 cfg_we,
	input  logic [vocg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vocg_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import vocg_pkg::*;

	// ---------------- configuration registers ----------------
	logic signed [POS_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [EXT_W-1:0]        extent_x_q, extent_y_q, extent_z_q;
	logic [INV_W-1:0]        inv_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			extent_x_q <= EXT_W'(16384);
			extent_y_q <= EXT_W'(16384);
			extent_z_q <= EXT_W'(8192);
			inv_res_q  <= INV_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data[POS_W-1:0];
				REG_ORIGIN_Y: origin_y_q <= cfg_data[POS_W-1:0];
				REG_ORIGIN_Z: origin_z_q <= cfg_data[POS_W-1:0];
				REG_EXTENT_X: extent_x_q <= cfg_data[EXT_W-1:0];
				REG_EXTENT_Y: extent_y_q <= cfg_data[EXT_W-1:0];
				REG_EXTENT_Z: extent_z_q <= cfg_data[EXT_W-1:0];
				REG_INV_RES:  inv_res_q  <= cfg_data[INV_W-1:0];
				default: ;  // unmapped index: ignored
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              out_valid_q;
	rsp_t              out_q;

	// Request datapath registers.
	req_t               item_q;
	logic               in_x_q, in_y_q, in_z_q;   // strictly inside origin..origin+extent
	logic [EXT_W-1:0]   dmag_x_q, dmag_y_q, dmag_z_q;
	logic [CELLV_W-1:0] cv_x_q, cv_y_q, cv_z_q;   // floor(diff * inv) per axis
	logic               ok_q;
	logic [ADDR_W-1:0]  addr_q;

	// Cell memory.
	cell_t             mem [CELL_COUNT];
	cell_t             rd_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	cell_t             mem_wdata;

	// Combinational helpers.
	logic               accept;
	logic               out_free;
	logic               load_out;
	rsp_t               rsp_d;
	logic [DIFF_W-1:0]  dif_x, dif_y, dif_z;
	logic [PROD_W-1:0]  prod_x, prod_y, prod_z;
	logic [CELLV_W-1:0] sel_x, sel_y, sel_z;
	logic               ok_d;
	logic [ADDR_W-1:0]  addr_d;
	logic [COST_BITS-1:0] cand;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Stage 1: signed offset from origin, inside test.
	assign dif_x = {item_q.pos_x[POS_W-1], item_q.pos_x} - {origin_x_q[POS_W-1], origin_x_q};
	assign dif_y = {item_q.pos_y[POS_W-1], item_q.pos_y} - {origin_y_q[POS_W-1], origin_y_q};
	assign dif_z = {item_q.pos_z[POS_W-1], item_q.pos_z} - {origin_z_q[POS_W-1], origin_z_q};

	// Stage 2: scale to cells (Q.8 times Q.8, drop 16 fraction bits).
	assign prod_x = PROD_W'(dmag_x_q) * PROD_W'(inv_res_q);
	assign prod_y = PROD_W'(dmag_y_q) * PROD_W'(inv_res_q);
	assign prod_z = PROD_W'(dmag_z_q) * PROD_W'(inv_res_q);

	// Stage 3: pick cell source, range check, linearize x-major.
	always_comb begin
		if (item_q.op == OP_READ_CELL) begin
			sel_x = CELLV_W'(item_q.cell_x);
			sel_y = CELLV_W'(item_q.cell_y);
			sel_z = CELLV_W'(item_q.cell_z);
			ok_d  = 1'b1;
		end else begin
			sel_x = cv_x_q;
			sel_y = cv_y_q;
			sel_z = cv_z_q;
			ok_d  = in_x_q && in_y_q && in_z_q;
		end
		ok_d = ok_d && (sel_x < CELLV_W'(GRID_X)) && (sel_y < CELLV_W'(GRID_Y))
			&& (sel_z < CELLV_W'(GRID_Z));
		addr_d = (ADDR_W'(sel_x) * ADDR_W'(GRID_Y) + ADDR_W'(sel_y)) * ADDR_W'(GRID_Z)
			+ ADDR_W'(sel_z);
	end

	assign cand = sat_cost_in(item_q.cost_value);

	// Next state, memory controls and result word.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = rd_q;
		load_out  = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == ADDR_W'(CELL_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_DIFF;
			end
			ST_DIFF:   state_d = ST_MUL;
			ST_MUL:    state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				mem_re  = 1'b1;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
					if (!ok_q) begin
						rsp_d.status = 1'b1;
					end else begin
						case (item_q.op)
							OP_SET_OCC: begin
								mem_we        = 1'b1;
								mem_wdata.occ = item_q.occ_value;
							end
							OP_RAISE_COST: begin
								if (cand > rd_q.cost) begin
									mem_we         = 1'b1;
									mem_wdata.cost = cand;
								end
							end
							OP_READ_POS: begin
								rsp_d.occupancy = rd_q.occ;
								rsp_d.cost      = sat_cost_out(rd_q.cost);
							end
							default: rsp_d.occupancy = rd_q.occ;  // read by cell
						endcase
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (load_out)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) item_q <= in_word;
		if (state_q == ST_DIFF) begin
			in_x_q   <= !dif_x[DIFF_W-1] && (dif_x != '0)
				&& (dif_x[POS_W-1:0] < {1'b0, extent_x_q});
			in_y_q   <= !dif_y[DIFF_W-1] && (dif_y != '0)
				&& (dif_y[POS_W-1:0] < {1'b0, extent_y_q});
			in_z_q   <= !dif_z[DIFF_W-1] && (dif_z != '0)
				&& (dif_z[POS_W-1:0] < {1'b0, extent_z_q});
			dmag_x_q <= dif_x[EXT_W-1:0];
			dmag_y_q <= dif_y[EXT_W-1:0];
			dmag_z_q <= dif_z[EXT_W-1:0];
		end
		if (state_q == ST_MUL) begin
			cv_x_q <= prod_x[PROD_W-1:FRAC_SH];
			cv_y_q <= prod_y[PROD_W-1:FRAC_SH];
			cv_z_q <= prod_z[PROD_W-1:FRAC_SH];
		end
		if (state_q == ST_LOOKUP) begin
			ok_q   <= ok_d;
			addr_q <= addr_d;
		end
		if (load_out) out_q <= rsp_d;
	end

	// Cell memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[addr_d];
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// ---------------- assertions ----------------
	a_write_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLEAR) |->
		(state_q == ST_COMMIT && ok_q
			&& (item_q.op == OP_SET_OCC || item_q.op == OP_RAISE_COST)))
		else $error("cell write outside a valid update commit");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("request taken during clearing pass");

	a_commit_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && out_valid_q && !out_ready) |=>
		(state_q == ST_COMMIT && $stable(out_q)))
		else $error("pending result overwritten");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result raised outside commit");

	a_outside_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status) |-> (!out_q.occupancy && out_q.cost == '0))
		else $error("outside result carries data");

endmodule
